@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define OLME_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("olme check failed");

// next-cycle implication, sampled on clk, off during reset
`define OLME_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olme check failed");

`endif

@@ src/olme_pkg.sv @@
package olme_pkg;

    localparam int OP_W     = 3;
    localparam int FIELD_W  = 16;
    localparam int POS_W    = 7;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_APPEND      = 3'd0;
    localparam logic [OP_W-1:0] OP_MOVE_BEFORE = 3'd1;
    localparam logic [OP_W-1:0] OP_MOVE_AFTER  = 3'd2;
    localparam logic [OP_W-1:0] OP_READ        = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND        = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_SAME      = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_ENCODE,
        S_DECIDE,
        S_REMOVE,
        S_INSERT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic match;
        logic encode;
        logic decide;
        logic append;
        logic remove;
        logic insert;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic append_ok;
        logic move;
    } sts_t;

endpackage

@@ src/olme_ctrl.sv @@
module olme_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  olme_pkg::sts_t    sts,
    output olme_pkg::cmd_t    cmd
);

    olme_pkg::state_t state_reg;
    olme_pkg::state_t state_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= olme_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            olme_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = olme_pkg::S_MATCH;
                end
            end
            olme_pkg::S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = olme_pkg::S_ENCODE;
            end
            olme_pkg::S_ENCODE:
            begin
                cmd.encode = 1'b1;
                state_next = olme_pkg::S_DECIDE;
            end
            olme_pkg::S_DECIDE:
            begin
                cmd.decide = 1'b1;
                cmd.append = sts.append_ok;
                state_next = sts.move ? olme_pkg::S_REMOVE : olme_pkg::S_EMIT;
            end
            olme_pkg::S_REMOVE:
            begin
                cmd.remove = 1'b1;
                state_next = olme_pkg::S_INSERT;
            end
            olme_pkg::S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = olme_pkg::S_EMIT;
            end
            olme_pkg::S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.emit      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = olme_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = olme_pkg::S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == olme_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

@@ src/olme_dp.sv @@
module olme_dp
#(
    parameter int MAX_LEN    = 64,
    parameter int VALUE_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  olme_pkg::cmd_t                       cmd,
    output olme_pkg::sts_t                       sts,
    input  logic [olme_pkg::OP_W-1:0]            opcode,
    input  logic [olme_pkg::FIELD_W-1:0]         item_value,
    input  logic [olme_pkg::FIELD_W-1:0]         target_value,
    input  logic [olme_pkg::POS_W-1:0]           position,
    output logic [olme_pkg::STAT_W-1:0]          status,
    output logic [olme_pkg::FIELD_W-1:0]         found_value,
    output logic [olme_pkg::POS_W-1:0]           found_position,
    output logic [olme_pkg::POS_W-1:0]           list_length
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = $clog2(MAX_LEN);

    logic [olme_pkg::OP_W-1:0]   op_reg;
    logic [VALUE_BITS-1:0]       x_reg;
    logic [VALUE_BITS-1:0]       y_reg;
    logic [olme_pkg::POS_W-1:0]  pos_reg;
    logic [VALUE_BITS-1:0]       cells_reg [MAX_LEN];
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [MAX_LEN-1:0]          mx_reg;
    logic [MAX_LEN-1:0]          my_reg;
    logic [CNT_W-1:0]            px_reg;
    logic [CNT_W-1:0]            py_reg;
    logic [CNT_W-1:0]            px_next;
    logic [CNT_W-1:0]            py_next;
    logic [VALUE_BITS-1:0]       rd_reg;
    logic                        pos_ok_reg;
    logic [IDX_W-1:0]            rd_idx;
    logic [CNT_W-1:0]            idx_reg;
    logic [CNT_W-1:0]            idx_next;
    logic [CNT_W-1:0]            py_adj;
    logic [olme_pkg::STAT_W-1:0] res_status_reg;
    logic [olme_pkg::STAT_W-1:0] res_status_next;
    logic [VALUE_BITS-1:0]       res_fval_reg;
    logic [VALUE_BITS-1:0]       res_fval_next;
    logic [CNT_W-1:0]            res_fpos_reg;
    logic [CNT_W-1:0]            res_fpos_next;
    logic [olme_pkg::STAT_W-1:0] status_reg;
    logic [olme_pkg::FIELD_W-1:0] found_value_reg;
    logic [olme_pkg::POS_W-1:0]  found_position_reg;
    logic [olme_pkg::POS_W-1:0]  list_length_reg;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            x_reg   <= VALUE_BITS'(item_value);
            y_reg   <= VALUE_BITS'(target_value);
            pos_reg <= position;
        end
    end

    // parallel compare across the occupied cells
    always_ff @(posedge clk)
    begin
        if (cmd.match)
        begin
            for (int i = 0; i < MAX_LEN; i++)
            begin
                mx_reg[i] <= (cells_reg[i] == x_reg) && (CNT_W'(i) < count_reg);
                my_reg[i] <= (cells_reg[i] == y_reg) && (CNT_W'(i) < count_reg);
            end
        end
    end

    // first match from the head, 1-based, zero if none
    always_comb
    begin
        px_next = '0;
        py_next = '0;
        for (int i = MAX_LEN - 1; i >= 0; i--)
        begin
            if (mx_reg[i])
            begin
                px_next = CNT_W'(i + 1);
            end
            if (my_reg[i])
            begin
                py_next = CNT_W'(i + 1);
            end
        end
    end

    assign rd_idx = IDX_W'(32'(pos_reg) - 32'd1);

    always_ff @(posedge clk)
    begin
        if (cmd.encode)
        begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            rd_reg     <= cells_reg[rd_idx];
            pos_ok_reg <= (pos_reg != '0) && (32'(pos_reg) <= 32'(count_reg));
        end
    end

    // y position after x is taken out, then the insert slot
    always_comb
    begin
        py_adj = (py_reg > px_reg) ? (py_reg - CNT_W'(1)) : py_reg;
        if (op_reg == olme_pkg::OP_MOVE_BEFORE)
        begin
            idx_next = py_adj - CNT_W'(1);
        end
        else
        begin
            idx_next = py_adj;
        end
    end

    always_comb
    begin
        res_status_next = olme_pkg::STAT_OK;
        res_fval_next   = '0;
        res_fpos_next   = '0;
        sts             = '0;
        unique case (op_reg) inside
            olme_pkg::OP_APPEND:
            begin
                if (count_reg >= CNT_W'(MAX_LEN))
                begin
                    res_status_next = olme_pkg::STAT_FULL;
                end
                else
                begin
                    sts.append_ok = 1'b1;
                end
            end
            olme_pkg::OP_MOVE_BEFORE, olme_pkg::OP_MOVE_AFTER:
            begin
                if (px_reg == '0 || py_reg == '0)
                begin
                    res_status_next = olme_pkg::STAT_NOT_FOUND;
                end
                else if (x_reg == y_reg)
                begin
                    res_status_next = olme_pkg::STAT_SAME;
                end
                else if ((op_reg == olme_pkg::OP_MOVE_BEFORE && px_reg == py_reg - CNT_W'(1))
                      || (op_reg == olme_pkg::OP_MOVE_AFTER && px_reg - CNT_W'(1) == py_reg))
                begin
                    res_status_next = olme_pkg::STAT_OK;
                end
                else
                begin
                    sts.move = 1'b1;
                end
            end
            olme_pkg::OP_READ:
            begin
                if (pos_ok_reg)
                begin
                    res_fval_next = rd_reg;
                end
                else
                begin
                    res_status_next = olme_pkg::STAT_NOT_FOUND;
                end
            end
            olme_pkg::OP_FIND:
            begin
                res_fpos_next = px_reg;
                if (px_reg == '0)
                begin
                    res_status_next = olme_pkg::STAT_NOT_FOUND;
                end
            end
            default:
            begin
                res_status_next = olme_pkg::STAT_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            res_status_reg <= res_status_next;
            res_fval_reg   <= res_fval_next;
            res_fpos_reg   <= res_fpos_next;
            idx_reg        <= idx_next;
        end
    end

    // cell row: each cell takes its own value, a neighbor, or x
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if (cmd.append && CNT_W'(i) == count_reg)
            begin
                cells_reg[i] <= x_reg;
            end
            else if (cmd.remove && CNT_W'(i) >= px_reg - CNT_W'(1) && i < MAX_LEN - 1)
            begin
                cells_reg[i] <= cells_reg[(i + 1) % MAX_LEN];
            end
            else if (cmd.insert && CNT_W'(i) == idx_reg)
            begin
                cells_reg[i] <= x_reg;
            end
            else if (cmd.insert && CNT_W'(i) > idx_reg && i > 0)
            begin
                cells_reg[i] <= cells_reg[(i + MAX_LEN - 1) % MAX_LEN];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.append || cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg         <= res_status_reg;
            found_value_reg    <= olme_pkg::FIELD_W'(res_fval_reg);
            found_position_reg <= olme_pkg::POS_W'(res_fpos_reg);
            list_length_reg    <= olme_pkg::POS_W'(count_reg);
        end
    end

    assign status         = status_reg;
    assign found_value    = found_value_reg;
    assign found_position = found_position_reg;
    assign list_length    = list_length_reg;

endmodule

@@ src/ordered_list_move_engine_core.sv @@
// each input word is taken only while the controller is idle, after the previous result is emitted
// the controller steps each word through compare, encode, decide and emit, adding a remove
// shift and an insert shift for a move that reorders the list
// a result word waiting on the output does not stall the next word's compare and decide
// reset: asynchronous active low, clears item count, controller state and output valid
// list contents are not cleared; only occupied cells ever reach a result
`include "assert_macros.svh"

module ordered_list_move_engine_core
#(
    parameter int MAX_LEN    = 64,
    parameter int VALUE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[2:0], item_value[18:3], target_value[34:19], position[41:35], zero fill
    input  logic [olme_pkg::S_DATA_W-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], found_value[17:2], found_position[24:18], list_length[31:25]
    output logic [olme_pkg::M_DATA_W-1:0] m_tdata
);

    olme_pkg::cmd_t cmd;
    olme_pkg::sts_t sts;

    logic [olme_pkg::STAT_W-1:0]  status;
    logic [olme_pkg::FIELD_W-1:0] found_value;
    logic [olme_pkg::POS_W-1:0]   found_position;
    logic [olme_pkg::POS_W-1:0]   list_length;

    olme_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    olme_dp
    #(
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .opcode         (s_tdata[2:0]),
        .item_value     (s_tdata[18:3]),
        .target_value   (s_tdata[34:19]),
        .position       (s_tdata[41:35]),
        .status         (status),
        .found_value    (found_value),
        .found_position (found_position),
        .list_length    (list_length)
    );

    assign m_tdata = {list_length, found_position, found_value, status};

    `OLME_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `OLME_ASSERT_IMP(a_find_pos_ok, m_tvalid && (m_tdata[24:18] != 7'd0), m_tdata[1:0] == olme_pkg::STAT_OK)
    `OLME_ASSERT_IMP(a_full_no_data, m_tvalid && (m_tdata[1:0] == olme_pkg::STAT_FULL), m_tdata[24:2] == 23'd0)

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int MAX_LEN = 64;
    localparam int IDLE_PERCENT = 34;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [olme_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [olme_pkg::OP_W-1:0] OP_SPARE_LAST = 3'd7;
    localparam logic [olme_pkg::FIELD_W-1:0] VAL_MAX = {olme_pkg::FIELD_W{1'b1}};
    localparam logic [olme_pkg::POS_W-1:0] POS_MAX = {olme_pkg::POS_W{1'b1}};

    // declared from the highest bit down so a cast matches the word layout
    typedef struct packed {
        logic [olme_pkg::POS_W-1:0] position;
        logic [olme_pkg::FIELD_W-1:0] target_value;
        logic [olme_pkg::FIELD_W-1:0] item_value;
        logic [olme_pkg::OP_W-1:0] opcode;
    } list_request_t;

    typedef struct packed {
        logic [olme_pkg::POS_W-1:0] list_length;
        logic [olme_pkg::POS_W-1:0] found_position;
        logic [olme_pkg::FIELD_W-1:0] found_value;
        logic [olme_pkg::STAT_W-1:0] status;
    } list_result_t;

    logic clk;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [olme_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [olme_pkg::M_DATA_W-1:0] m_tdata;

    logic [olme_pkg::FIELD_W-1:0] list_vals[$];
    list_result_t expected_results[$];
    int error_count = 0;
    int quiet_cycles = 0;
    bit steady = 1'b0;

    ordered_list_move_engine_core #(
        .MAX_LEN(MAX_LEN),
        .VALUE_BITS(olme_pkg::FIELD_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // first position of a value, 0 if absent
    function automatic int locate_value(logic [olme_pkg::FIELD_W-1:0] v);
        for (int i = 0; i < list_vals.size(); i++)
        begin
            if (list_vals[i] == v)
                return i + 1;
        end
        return 0;
    endfunction

    function automatic list_result_t apply_list_request(list_request_t req);
        list_result_t res;
        int px;
        int py;
        res = '0;
        res.status = olme_pkg::STAT_OK;
        case (req.opcode)
            olme_pkg::OP_APPEND:
            begin
                if (list_vals.size() >= MAX_LEN)
                    res.status = olme_pkg::STAT_FULL;
                else
                    list_vals.push_back(req.item_value);
            end
            olme_pkg::OP_MOVE_BEFORE, olme_pkg::OP_MOVE_AFTER:
            begin
                px = locate_value(req.item_value);
                py = locate_value(req.target_value);
                if (px == 0 || py == 0)
                    res.status = olme_pkg::STAT_NOT_FOUND;
                else if (req.item_value == req.target_value)
                    res.status = olme_pkg::STAT_SAME;
                else if (!((req.opcode == olme_pkg::OP_MOVE_BEFORE && px + 1 == py) ||
                           (req.opcode == olme_pkg::OP_MOVE_AFTER && px == py + 1)))
                begin
                    list_vals.delete(px - 1);
                    py = locate_value(req.target_value);
                    list_vals.insert(req.opcode == olme_pkg::OP_MOVE_BEFORE ? py - 1 : py,
                                     req.item_value);
                end
            end
            olme_pkg::OP_READ:
            begin
                if (req.position >= 1 && req.position <= list_vals.size())
                    res.found_value = list_vals[req.position - 1];
                else
                    res.status = olme_pkg::STAT_NOT_FOUND;
            end
            olme_pkg::OP_FIND:
            begin
                res.found_position = olme_pkg::POS_W'(locate_value(req.item_value));
                if (res.found_position == 0)
                    res.status = olme_pkg::STAT_NOT_FOUND;
            end
            default:
                res.status = olme_pkg::STAT_NOT_FOUND;
        endcase
        res.list_length = olme_pkg::POS_W'(list_vals.size());
        return res;
    endfunction

    // values already in the list at hit_percent, else a quarter from a small pool to force repeats
    function automatic logic [olme_pkg::FIELD_W-1:0] pick_value(int hit_percent);
        if (list_vals.size() > 0 && $urandom_range(0, 99) < hit_percent)
            return list_vals[$urandom_range(0, list_vals.size() - 1)];
        if ($urandom_range(0, 3) == 0)
            return olme_pkg::FIELD_W'($urandom_range(0, 7));
        return olme_pkg::FIELD_W'($urandom());
    endfunction

    task automatic send_word(logic [olme_pkg::OP_W-1:0] opcode,
                             logic [olme_pkg::FIELD_W-1:0] item_value,
                             logic [olme_pkg::FIELD_W-1:0] target_value,
                             logic [olme_pkg::POS_W-1:0] position);
        list_request_t req;
        req = '{position: position, target_value: target_value,
                item_value: item_value, opcode: opcode};
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= olme_pkg::S_DATA_W'(req);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(apply_list_request(req));
    endtask

    task automatic test_empty_list();
        send_word(olme_pkg::OP_READ, '0, '0, '0);
        send_word(olme_pkg::OP_FIND, '0, '0, olme_pkg::POS_W'(1));
        send_word(olme_pkg::OP_MOVE_BEFORE, olme_pkg::FIELD_W'(1), olme_pkg::FIELD_W'(2), '0);
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            send_word(olme_pkg::OP_W'(op), VAL_MAX, VAL_MAX, POS_MAX);
    endtask

    task automatic test_short_list();
        send_word(olme_pkg::OP_APPEND, '0, VAL_MAX, POS_MAX);
        send_word(olme_pkg::OP_APPEND, VAL_MAX, '0, '0);
        send_word(olme_pkg::OP_APPEND, 16'h1234, '0, '0);
        send_word(olme_pkg::OP_APPEND, VAL_MAX, '0, '0);
        send_word(olme_pkg::OP_APPEND, 16'h00aa, '0, '0);
        send_word(olme_pkg::OP_READ, '0, '0, olme_pkg::POS_W'(1));
        send_word(olme_pkg::OP_READ, '0, '0, olme_pkg::POS_W'(5));
        send_word(olme_pkg::OP_READ, '0, '0, olme_pkg::POS_W'(6));
        send_word(olme_pkg::OP_READ, '0, '0, POS_MAX);
        // repeated value answers with its first position
        send_word(olme_pkg::OP_FIND, VAL_MAX, '0, '0);
        send_word(olme_pkg::OP_FIND, 16'h5555, '0, '0);
        // already in place on either side, then item and target the same
        send_word(olme_pkg::OP_MOVE_BEFORE, '0, VAL_MAX, '0);
        send_word(olme_pkg::OP_MOVE_AFTER, 16'h1234, VAL_MAX, '0);
        send_word(olme_pkg::OP_MOVE_BEFORE, 16'h1234, 16'h1234, '0);
        // absent item wins over same item, then an absent target and two real moves
        send_word(olme_pkg::OP_MOVE_AFTER, 16'h7777, 16'h7777, '0);
        send_word(olme_pkg::OP_MOVE_BEFORE, '0, 16'h7777, '0);
        send_word(olme_pkg::OP_MOVE_BEFORE, 16'h00aa, '0, '0);
        send_word(olme_pkg::OP_MOVE_AFTER, 16'h00aa, VAL_MAX, '0);
    endtask

    task automatic test_random_ops(int count);
        int pick;
        logic [olme_pkg::POS_W-1:0] pos;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_word(olme_pkg::OP_APPEND, pick_value(30), olme_pkg::FIELD_W'($urandom()),
                          olme_pkg::POS_W'($urandom()));
            else if (pick < 58)
                send_word($urandom_range(0, 1) ? olme_pkg::OP_MOVE_BEFORE
                                               : olme_pkg::OP_MOVE_AFTER,
                          pick_value(85), pick_value(85), olme_pkg::POS_W'($urandom()));
            else if (pick < 73)
            begin
                if (list_vals.size() > 0 && $urandom_range(0, 99) < 70)
                    pos = olme_pkg::POS_W'($urandom_range(1, list_vals.size()));
                else
                    pos = olme_pkg::POS_W'($urandom());
                send_word(olme_pkg::OP_READ, olme_pkg::FIELD_W'($urandom()),
                          olme_pkg::FIELD_W'($urandom()), pos);
            end
            else if (pick < 92)
                send_word(olme_pkg::OP_FIND, pick_value(60), olme_pkg::FIELD_W'($urandom()),
                          olme_pkg::POS_W'($urandom()));
            else
                send_word(olme_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                          olme_pkg::FIELD_W'($urandom()), olme_pkg::FIELD_W'($urandom()),
                          olme_pkg::POS_W'($urandom()));
        end
    endtask

    task automatic test_full_list();
        while (list_vals.size() < MAX_LEN)
            send_word(olme_pkg::OP_APPEND, pick_value(20), '0, '0);
        send_word(olme_pkg::OP_APPEND, '0, '0, '0);
        send_word(olme_pkg::OP_APPEND, VAL_MAX, VAL_MAX, POS_MAX);
        send_word(olme_pkg::OP_READ, '0, '0, olme_pkg::POS_W'(MAX_LEN));
        send_word(olme_pkg::OP_READ, '0, '0, olme_pkg::POS_W'(MAX_LEN + 1));
        send_word(olme_pkg::OP_MOVE_AFTER, list_vals[0], list_vals[MAX_LEN - 1], '0);
        send_word(olme_pkg::OP_MOVE_BEFORE, list_vals[MAX_LEN - 1], list_vals[0], '0);
        send_word(olme_pkg::OP_FIND, list_vals[MAX_LEN - 1], '0, '0);
    endtask

    task automatic test_back_to_back(int count);
        steady = 1'b1;
        test_random_ops(count);
        steady = 1'b0;
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);

    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_results.size() == 0)
            begin
                $error("result word with no request outstanding: %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("found_value", 32'(want.found_value), 32'(got.found_value));
                check_field("found_position", 32'(want.found_position),
                            32'(got.found_position));
                check_field("list_length", 32'(want.list_length), 32'(got.list_length));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_short_list();
        test_random_ops(900);
        test_full_list();
        test_back_to_back(80);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
